@@ design/altbl_pkg.sv @@
`timescale 1ns / 1ps

package altbl_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int PAY_W    = 64;
	localparam int POS_W    = 7;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		FN_INS_END   = 3'd0,
		FN_INS_FRONT = 3'd1,
		FN_INS_SORT  = 3'd2,
		FN_RM_END    = 3'd3,
		FN_RM_FRONT  = 3'd4,
		FN_RM_KEY    = 3'd5,
		FN_READ      = 3'd6,
		FN_FIND      = 3'd7
	} func_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_APPLY = 1'b1
	} state_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic take_left;
		logic take_right;
	} cell_ctl_t;

endpackage

@@ design/altbl_cell.sv @@
`timescale 1ns / 1ps

module altbl_cell import altbl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [IDX_W-1:0]        idx,
	input  cell_ctl_t               ctl,
	input  func_t                   func,
	input  logic signed [KEY_W-1:0] key,
	input  logic [POS_W-1:0]        pos,
	input  logic [CNT_W-1:0]        count,
	input  entry_t                  new_entry,
	input  entry_t                  left,
	input  entry_t                  right,
	output entry_t                  entry,
	output logic                    hit
);

	entry_t entry_q;
	logic   hit_q;
	logic   occupied;
	logic   cond;

	assign occupied = CNT_W'(idx) < count;

	always_comb begin
		case (func)
			FN_INS_FRONT, FN_RM_FRONT: cond = 1'b1;
			FN_INS_SORT:               cond = !($signed(entry_q.key) < $signed(key));
			FN_RM_KEY, FN_FIND:        cond = ($signed(entry_q.key) == $signed(key));
			FN_READ:                   cond = (CMP_W'(idx) + CMP_W'(1)) == CMP_W'(pos);
			default:                   cond = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.capture) begin
			hit_q <= occupied & cond;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= new_entry;
		end else if (ctl.take_left) begin
			entry_q <= left;
		end else if (ctl.take_right) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

@@ design/array_list_table_engine.sv @@
`timescale 1ns / 1ps
// The result is registered in the cycle after the accepting edge.
// Items are taken one at a time; each cell compares its entry in the
// accept cycle, and all cells shift or load in parallel in the next cycle.
// A result still waiting for the receiver holds off the next item.
// Reset: count, handshake and state clear; entry storage is not reset and
// holds only what has been written.

module array_list_table_engine import altbl_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic [2:0]              func,
	input  logic signed [KEY_W-1:0] record_key,
	input  logic [PAY_W-1:0]        record_payload,
	input  logic [POS_W-1:0]        position,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic                    success,
	output logic signed [KEY_W-1:0] found_key,
	output logic [PAY_W-1:0]        found_payload,
	output logic [CNT_W-1:0]        entry_count,
	output logic                    is_full,
	output logic                    is_empty
);

	state_t                  state_q, state_d;
	logic                    accept;
	logic                    apply_en;
	func_t                   func_q;
	entry_t                  req_entry_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	logic [CAPACITY-1:0]     hits;
	logic [CAPACITY-1:0]     tail_oh;
	logic [CAPACITY-1:0]     sel;
	logic [CAPACITY-1:0]     first;
	logic [CAPACITY-1:0]     from_first;
	logic [CAPACITY-1:0]     after;
	logic                    is_ins;
	logic                    is_rm_shift;
	logic                    is_lookup;
	logic                    ok;
	entry_t                  found;
	entry_t                  ent [CAPACITY];
	cell_ctl_t               ctl [CAPACITY];

	logic                    rsp_valid_q;
	logic                    success_q;
	entry_t                  found_q;
	logic [CNT_W-1:0]        count_out_q;
	logic                    full_q;
	logic                    empty_q;

	assign accept = req_valid & req_ready;

	always_comb begin
		case (state_q)
			ST_IDLE:  state_d = accept ? ST_APPLY : ST_IDLE;
			ST_APPLY: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IDLE: begin
				req_ready = !rsp_valid_q | rsp_ready;
				apply_en  = 1'b0;
			end
			ST_APPLY: begin
				req_ready = 1'b0;
				apply_en  = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
				apply_en  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q <= FN_INS_END;
		end else if (accept) begin
			func_q <= func_t'(func);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_entry_q.key     <= record_key;
			req_entry_q.payload <= record_payload;
		end
	end

	// Pick the position: first hit, or the tail slot for inserts.
	always_comb begin
		is_ins      = (func_q == FN_INS_END) || (func_q == FN_INS_FRONT) ||
		              (func_q == FN_INS_SORT);
		is_rm_shift = (func_q == FN_RM_FRONT) || (func_q == FN_RM_KEY);
		is_lookup   = (func_q == FN_READ) || (func_q == FN_FIND);
		tail_oh     = CAPACITY'(1) << count_q;
		sel         = is_ins ? (hits | tail_oh) : hits;
		first       = sel & (~sel + CAPACITY'(1));
		from_first  = ~(first - CAPACITY'(1));
		after       = from_first & ~first;
	end

	always_comb begin
		case (func_q)
			FN_INS_END, FN_INS_FRONT, FN_INS_SORT: ok = count_q != CNT_W'(CAPACITY);
			FN_RM_END, FN_RM_FRONT:                ok = count_q != '0;
			FN_RM_KEY, FN_READ, FN_FIND:           ok = |hits;
			default:                               ok = 1'b0;
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (ok && is_ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ok && !is_lookup) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (apply_en) begin
			count_q <= count_d;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;

		if (i == 0) begin : g_head
			assign left_e = '0;
		end else begin : g_mid_l
			assign left_e = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_mid_r
			assign right_e = ent[i+1];
		end

		assign ctl[i].capture    = accept;
		assign ctl[i].load       = apply_en & ok & is_ins & first[i];
		assign ctl[i].take_left  = apply_en & ok & is_ins & after[i];
		assign ctl[i].take_right = apply_en & ok & is_rm_shift & from_first[i];

		altbl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(i)),
			.ctl       (ctl[i]),
			.func      (func_t'(func)),
			.key       (record_key),
			.pos       (position),
			.count     (count_q),
			.new_entry (req_entry_q),
			.left      (left_e),
			.right     (right_e),
			.entry     (ent[i]),
			.hit       (hits[i])
		);
	end

	always_comb begin
		found = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			found = found | (ent[i] & {$bits(entry_t){first[i]}});
		end
		if (!is_lookup) begin
			found = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (apply_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_en) begin
			success_q   <= ok;
			found_q     <= found;
			count_out_q <= count_d;
			full_q      <= count_d == CNT_W'(CAPACITY);
			empty_q     <= count_d == '0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign success       = success_q;
	assign found_key     = found_q.key;
	assign found_payload = found_q.payload;
	assign entry_count   = count_out_q;
	assign is_full       = full_q;
	assign is_empty      = empty_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPLY |-> !rsp_valid_q)
		else $error("result register busy during apply");

	a_apply_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPLY |=> rsp_valid)
		else $error("apply gave no result");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |=> $stable(count_q))
		else $error("count moved outside apply");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import altbl_pkg::*;

	localparam int LIVE           = 0;
	localparam int SHADOW         = 1;
	localparam int BATCH_ITEMS    = 250;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MIXED_ITEMS    = 60;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum int {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_t;

	typedef struct packed {
		func_t                   fn;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        pay;
		logic [POS_W-1:0]        pos;
	} list_req_t;

	typedef struct packed {
		logic                    ok;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        pay;
		logic [CNT_W-1:0]        cnt;
		logic                    full;
		logic                    empty;
	} list_rsp_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_ready;
	logic [2:0]              func = 3'd0;
	logic signed [KEY_W-1:0] record_key = '0;
	logic [PAY_W-1:0]        record_payload = '0;
	logic [POS_W-1:0]        position = '0;
	logic                    rsp_valid;
	logic                    rsp_ready = 1'b0;
	logic                    success;
	logic signed [KEY_W-1:0] found_key;
	logic [PAY_W-1:0]        found_payload;
	logic [CNT_W-1:0]        entry_count;
	logic                    is_full;
	logic                    is_empty;

	logic signed [KEY_W-1:0] lst_key [2][CAPACITY];
	logic [PAY_W-1:0]        lst_pay [2][CAPACITY];
	int                      lst_cnt [2];

	list_req_t  queued_requests[$];
	list_rsp_t  pending_results[$];
	idle_mode_t idle_mode = IDLE_NONE;
	trend_t     trend = TREND_FILL;
	int         overrun = 0;
	int         mixed_left = 0;
	int         errors = 0;
	int         quiet_cycles = 0;
	int         hold_cnt = 0;
	bit         hold_go = 1'b0;
	bit         hold_seen = 1'b0;

	array_list_table_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.func           (func),
		.record_key     (record_key),
		.record_payload (record_payload),
		.position       (position),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.success        (success),
		.found_key      (found_key),
		.found_payload  (found_payload),
		.entry_count    (entry_count),
		.is_full        (is_full),
		.is_empty       (is_empty)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic list_rsp_t list_op(input int m, input list_req_t r);
		list_rsp_t o;
		int        n;
		int        i;
		int        k;
		o = '0;
		n = lst_cnt[m];
		i = 0;
		case (r.fn)
			FN_INS_END, FN_INS_FRONT, FN_INS_SORT: begin
				if (n < CAPACITY) begin
					if (r.fn == FN_INS_END)
						i = n;
					else if (r.fn == FN_INS_SORT)
						while (i < n && $signed(lst_key[m][i]) < $signed(r.key))
							i++;
					for (k = n; k > i; k--) begin
						lst_key[m][k] = lst_key[m][k-1];
						lst_pay[m][k] = lst_pay[m][k-1];
					end
					lst_key[m][i] = r.key;
					lst_pay[m][i] = r.pay;
					n++;
					o.ok = 1'b1;
				end
			end
			FN_RM_END, FN_RM_FRONT: begin
				if (n > 0) begin
					if (r.fn == FN_RM_FRONT)
						for (k = 0; k + 1 < n; k++) begin
							lst_key[m][k] = lst_key[m][k+1];
							lst_pay[m][k] = lst_pay[m][k+1];
						end
					n--;
					o.ok = 1'b1;
				end
			end
			FN_RM_KEY, FN_FIND: begin
				while (i < n && lst_key[m][i] != r.key)
					i++;
				if (i < n) begin
					o.ok = 1'b1;
					if (r.fn == FN_FIND) begin
						o.key = lst_key[m][i];
						o.pay = lst_pay[m][i];
					end else begin
						for (k = i; k + 1 < n; k++) begin
							lst_key[m][k] = lst_key[m][k+1];
							lst_pay[m][k] = lst_pay[m][k+1];
						end
						n--;
					end
				end
			end
			default: begin
				if (int'(r.pos) >= 1 && int'(r.pos) <= n) begin
					o.ok  = 1'b1;
					o.key = lst_key[m][r.pos-1];
					o.pay = lst_pay[m][r.pos-1];
				end
			end
		endcase
		lst_cnt[m] = n;
		o.cnt   = CNT_W'(n);
		o.full  = (n == CAPACITY);
		o.empty = (n == 0);
		return o;
	endfunction

	task automatic queue_item(input func_t fn, input logic signed [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay, input logic [POS_W-1:0] pos);
		list_req_t r;
		list_rsp_t unused;
		r = '{fn: fn, key: key, pay: pay, pos: pos};
		unused = list_op(SHADOW, r);
		queued_requests.push_back(r);
	endtask

	task automatic queue_random_item();
		list_req_t r;
		int        n;
		int        pick;
		n = lst_cnt[SHADOW];
		if (trend == TREND_FILL && n == CAPACITY) begin
			overrun++;
			if (overrun > 3) begin
				trend = TREND_DRAIN;
				overrun = 0;
			end
		end else if (trend == TREND_DRAIN && n == 0) begin
			overrun++;
			if (overrun > 3) begin
				trend = TREND_MIXED;
				mixed_left = MIXED_ITEMS;
				overrun = 0;
			end
		end else if (trend == TREND_MIXED) begin
			mixed_left--;
			if (mixed_left <= 0)
				trend = TREND_FILL;
		end
		pick = $urandom_range(0, 99);
		if (trend == TREND_MIXED)
			r.fn = func_t'($urandom_range(0, 7));
		else if (pick < 80)
			r.fn = func_t'(trend == TREND_FILL ? $urandom_range(0, 2) : $urandom_range(3, 5));
		else if (pick < 92)
			r.fn = func_t'($urandom_range(6, 7));
		else
			r.fn = func_t'(trend == TREND_FILL ? $urandom_range(3, 5) : $urandom_range(0, 2));
		pick = $urandom_range(0, 9);
		if (pick < 4 && n > 0)
			r.key = lst_key[SHADOW][$urandom_range(0, n - 1)];
		else if (pick < 7)
			r.key = int'($urandom_range(0, 15)) - 8;
		else if (pick == 7)
			case ($urandom_range(0, 3))
				0: r.key = 32'sh8000_0000;
				1: r.key = 32'sh7fff_ffff;
				2: r.key = '0;
				default: r.key = '1;
			endcase
		else
			r.key = $urandom;
		r.pay = {$urandom, $urandom};
		pick = $urandom_range(0, 9);
		if (pick < 7)
			r.pos = POS_W'($urandom_range(1, n > 0 ? n : 1));
		else if (pick == 7)
			r.pos = '0;
		else if (pick == 8)
			r.pos = POS_W'(n + 1);
		else
			r.pos = POS_W'($urandom_range(0, 127));
		queue_item(r.fn, r.key, r.pay, r.pos);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin : drive_requests
			list_req_t nxt;
			if (req_valid && req_ready)
				pending_results.push_back(list_op(LIVE,
					'{fn: func_t'(func), key: record_key, pay: record_payload,
					pos: position}));
			if (!req_valid || req_ready) begin
				if (queued_requests.size() > 0 && $urandom_range(0, 99) >=
						(idle_mode == IDLE_SENDER ? 46 : idle_mode == IDLE_BOTH ? 6 : 0)) begin
					nxt = queued_requests.pop_front();
					func           <= nxt.fn;
					record_key     <= nxt.key;
					record_payload <= nxt.pay;
					position       <= nxt.pos;
					req_valid      <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_go && !hold_seen) begin
			hold_seen <= 1'b1;
			hold_cnt  <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt  <= hold_cnt - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= $urandom_range(0, 99) >=
				(idle_mode == IDLE_RECEIVER ? 46 : idle_mode == IDLE_BOTH ? 6 : 0);
		end
	end

	always @(posedge clk) begin : check_results
		list_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unrequested item", entry_count, 0);
			end else begin
				want = pending_results.pop_front();
				if (success !== want.ok)
					report_mismatch("success", success, want.ok);
				if (found_key !== want.key)
					report_mismatch("found_key", found_key, want.key);
				if (found_payload !== want.pay)
					report_mismatch("found_payload", found_payload, want.pay);
				if (entry_count !== want.cnt)
					report_mismatch("entry_count", entry_count, want.cnt);
				if (is_full !== want.full)
					report_mismatch("is_full", is_full, want.full);
				if (is_empty !== want.empty)
					report_mismatch("is_empty", is_empty, want.empty);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("** array_list_table_engine: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int m;
		lst_cnt[LIVE]   = 0;
		lst_cnt[SHADOW] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_item(FN_RM_END, 0, 0, 0);
		queue_item(FN_RM_FRONT, 0, 0, 0);
		queue_item(FN_RM_KEY, 5, 0, 0);
		queue_item(FN_FIND, 0, 0, 0);
		queue_item(FN_READ, 0, 0, 1);
		queue_item(FN_INS_SORT, 0, 64'h0, 0);
		queue_item(FN_INS_SORT, 32'sh7fff_ffff, '1, 0);
		queue_item(FN_INS_SORT, 32'sh8000_0000, 64'h0123_4567_89ab_cdef, 0);
		queue_item(FN_INS_SORT, 0, 64'h1, 0);
		queue_item(FN_INS_FRONT, -1, 64'hfedc_ba98_7654_3210, '1);
		queue_item(FN_INS_END, 7, 64'h5555_aaaa_5555_aaaa, 0);
		queue_item(FN_READ, 0, 0, 0);
		queue_item(FN_READ, 0, 0, 1);
		queue_item(FN_READ, 0, 0, 6);
		queue_item(FN_READ, 0, 0, 7);
		queue_item(FN_READ, 0, 0, 127);
		queue_item(FN_FIND, 0, 0, 0);
		queue_item(FN_FIND, 12345, 0, 0);
		queue_item(FN_RM_KEY, 0, 0, 0);
		queue_item(FN_RM_KEY, 999, 0, 0);
		queue_item(FN_RM_FRONT, 0, 0, 0);
		queue_item(FN_RM_END, 0, 0, 0);
		queue_item(FN_INS_SORT, -5, 64'h8000_0000_0000_0000, 0);
		queue_item(FN_READ, 0, 0, 1);

		for (m = 0; m < 4; m++) begin
			while (queued_requests.size() > 0)
				@(negedge clk);
			idle_mode = idle_mode_t'(m);
			if (idle_mode == IDLE_NONE)
				hold_go = 1'b1;
			repeat (BATCH_ITEMS)
				queue_random_item();
		end

		while (queued_requests.size() > 0 || req_valid)
			@(negedge clk);
		while (pending_results.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		if (errors == 0)
			$display("** array_list_table_engine: PASSED **");
		else
			$display("** array_list_table_engine: FAILED **");
		$finish;
	end

endmodule

@@ array_list_table_engine.f @@
design/altbl_pkg.sv
design/altbl_cell.sv
design/array_list_table_engine.sv
tb/tb.sv
